[hw/rtl/utf8_stream_transcoder_assert.svh]
// Assertion macros for the transcoder. Both expect signals named clock and reset in scope.
`ifndef UTF8_STREAM_TRANSCODER_ASSERT_SVH
`define UTF8_STREAM_TRANSCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTF8ST_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTF8ST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/utf8st_pkg.sv]
`timescale 1ns / 1ps
package utf8st_pkg;

   localparam int BYTE_W    = 8;
   localparam int UNIT_W    = 21;
   localparam int ERR_W     = 3;
   localparam int LEN_W     = 3;
   localparam int FORM_W    = 2;
   localparam int MAX_BYTES = 4;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [FORM_W-1:0] FORM_UTF32 = 2'd0;
   localparam logic [FORM_W-1:0] FORM_UTF16 = 2'd1;
   localparam logic [FORM_W-1:0] FORM_UTF8  = 2'd2;

   localparam logic [UNIT_W-1:0] CP_LIMIT  = 21'h110000;
   localparam logic [UNIT_W-1:0] SUPP_BASE = 21'h010000;
   localparam logic [UNIT_W-1:0] HI_SURR   = 21'h00D800;
   localparam logic [UNIT_W-1:0] LO_SURR   = 21'h00DC00;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE     = 3'd0,
      ERR_BAD_LEAD = 3'd1,
      ERR_BAD_CONT = 3'd2,
      ERR_TRUNC    = 3'd3,
      ERR_RANGE    = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_ERROR,
      ACT_DONE
   } action_type;

   typedef struct packed {
      logic                                 pre_err;
      action_type                           act;
      err_type                              err;
      logic [FORM_W-1:0]                    form;
      logic [LEN_W-1:0]                     len;
      logic [UNIT_W-1:0]                    cp;
      logic [MAX_BYTES-1:0][BYTE_W-1:0]     bytes;
   } job_type;

   typedef struct packed {
      logic [UNIT_W-1:0] value;
      err_type           err;
   } item_type;

endpackage

[hw/rtl/utf8st_if.sv]
`timescale 1ns / 1ps
interface utf8st_req_if import utf8st_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_stream;

   modport source (output valid, in_byte, end_of_stream, input ready);
   modport sink (input valid, in_byte, end_of_stream, output ready);
endinterface

interface utf8st_rsp_if import utf8st_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [UNIT_W-1:0] unit_value;
   logic [ERR_W-1:0]  error_kind;
   logic              last_of_run;

   modport source (output valid, unit_value, error_kind, last_of_run, input ready);
   modport sink (input valid, unit_value, error_kind, last_of_run, output ready);
endinterface

[hw/rtl/utf8st_front.sv]
`timescale 1ns / 1ps
module utf8st_front import utf8st_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   utf8st_req_if.sink        req,
   input  logic [FORM_W-1:0] form,
   input  logic              q_full,
   output logic              push,
   output job_type           push_job
);

   logic [LEN_W-1:0]                 exp_ff, exp_in;
   logic [LEN_W-1:0]                 rcv_ff, rcv_in;
   logic [UNIT_W-1:0]                partial_ff, partial_in;
   logic [MAX_BYTES-1:0][BYTE_W-1:0] held_ff, held_in;

   logic              accept;
   logic [BYTE_W-1:0] b;
   logic              is_cont;
   logic [LEN_W-1:0]  lead_len;
   logic [UNIT_W-1:0] lead_bits;
   logic [LEN_W-1:0]  cnt_next;
   logic [UNIT_W-1:0] new_cp;
   logic              held_we;
   logic [1:0]        held_idx;
   job_type           job;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.in_byte;
   assign is_cont   = (b[7:6] == 2'b10);
   assign cnt_next  = rcv_ff + LEN_W'(1);
   assign new_cp    = {partial_ff[UNIT_W-7:0], b[5:0]};

   always_comb begin
      lead_len  = '0;
      lead_bits = '0;
      if (!b[7]) begin
         lead_len  = LEN_W'(1);
         lead_bits = UNIT_W'(b);
      end else if (b[7:5] == 3'b110) begin
         lead_len  = LEN_W'(2);
         lead_bits = UNIT_W'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
         lead_len  = LEN_W'(3);
         lead_bits = UNIT_W'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
         lead_len  = LEN_W'(4);
         lead_bits = UNIT_W'(b[2:0]);
      end
   end

   always_comb begin
      exp_in     = exp_ff;
      rcv_in     = rcv_ff;
      partial_in = partial_ff;
      held_we    = 1'b0;
      held_idx   = '0;
      job        = '0;
      job.act    = ACT_NONE;
      job.err    = ERR_NONE;
      job.form   = form;
      if (exp_ff != '0 && is_cont) begin
         held_we  = 1'b1;
         held_idx = rcv_ff[1:0];
         if (cnt_next >= exp_ff) begin
            job.act = ACT_DONE;
            job.cp  = new_cp;
            job.len = exp_ff;
            exp_in  = '0;
            rcv_in  = '0;
         end else if (req.end_of_stream) begin
            job.act = ACT_ERROR;
            job.err = ERR_TRUNC;
            exp_in  = '0;
            rcv_in  = '0;
         end else begin
            rcv_in     = cnt_next;
            partial_in = new_cp;
         end
      end else begin
         job.pre_err = (exp_ff != '0);
         exp_in      = '0;
         rcv_in      = '0;
         if (lead_len == '0) begin
            job.act = ACT_ERROR;
            job.err = ERR_BAD_LEAD;
         end else begin
            held_we = 1'b1;
            if (lead_len == LEN_W'(1)) begin
               job.act = ACT_DONE;
               job.cp  = lead_bits;
               job.len = lead_len;
            end else if (req.end_of_stream) begin
               job.act = ACT_ERROR;
               job.err = ERR_TRUNC;
            end else begin
               exp_in     = lead_len;
               rcv_in     = LEN_W'(1);
               partial_in = lead_bits;
            end
         end
      end
      held_in = held_ff;
      if (held_we) begin
         held_in[held_idx] = b;
      end
      job.bytes = held_in;
   end

   assign push     = accept && (job.pre_err || job.act != ACT_NONE);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff <= '0;
         rcv_ff <= '0;
      end else if (accept) begin
         exp_ff <= exp_in;
         rcv_ff <= rcv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         partial_ff <= partial_in;
         held_ff    <= held_in;
      end
   end

endmodule

[hw/rtl/utf8st_queue.sv]
`timescale 1ns / 1ps
module utf8st_queue import utf8st_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output job_type pop_job
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   job_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[hw/rtl/utf8st_back.sv]
`timescale 1ns / 1ps
module utf8st_back import utf8st_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    pop,
   utf8st_rsp_if.source rsp
);

   item_type          items [MAX_BYTES];
   logic [LEN_W-1:0]  n_items;
   logic [LEN_W-1:0]  k;
   logic [UNIT_W-1:0] v;

   logic [1:0]        idx_ff, idx_in;
   logic              valid_ff, valid_in;
   item_type          item_ff, item_in;
   logic              last_ff, last_in;
   logic              load;
   logic              is_last;

   always_comb begin
      for (int i = 0; i < MAX_BYTES; i++) begin
         items[i] = '{value: '0, err: ERR_NONE};
      end
      k = '0;
      v = job.cp - SUPP_BASE;
      if (job.pre_err) begin
         items[0] = '{value: '0, err: ERR_BAD_CONT};
         k = LEN_W'(1);
      end
      case (job.act)
         ACT_ERROR: begin
            items[k[1:0]] = '{value: '0, err: job.err};
            k = k + LEN_W'(1);
         end
         ACT_DONE: begin
            case (job.form)
               FORM_UTF8: begin
                  for (int i = 0; i < MAX_BYTES; i++) begin
                     if (LEN_W'(i) < job.len) begin
                        items[k[1:0]] = '{value: UNIT_W'(job.bytes[i]), err: ERR_NONE};
                        k = k + LEN_W'(1);
                     end
                  end
               end
               FORM_UTF16: begin
                  if (job.cp >= CP_LIMIT) begin
                     items[k[1:0]] = '{value: '0, err: ERR_RANGE};
                     k = k + LEN_W'(1);
                  end else if (job.cp < SUPP_BASE) begin
                     items[k[1:0]] = '{value: job.cp, err: ERR_NONE};
                     k = k + LEN_W'(1);
                  end else begin
                     items[k[1:0]] = '{value: HI_SURR | UNIT_W'(v[19:10]), err: ERR_NONE};
                     k = k + LEN_W'(1);
                     items[k[1:0]] = '{value: LO_SURR | UNIT_W'(v[9:0]), err: ERR_NONE};
                     k = k + LEN_W'(1);
                  end
               end
               default: begin
                  items[k[1:0]] = '{value: job.cp, err: ERR_NONE};
                  k = k + LEN_W'(1);
               end
            endcase
         end
         default: begin
         end
      endcase
      n_items = k;
   end

   assign load    = job_valid && (!valid_ff || rsp.ready);
   assign is_last = (LEN_W'(idx_ff) + LEN_W'(1) == n_items);
   assign pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      item_in  = item_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = items[idx_ff];
         last_in  = is_last;
         idx_in   = is_last ? '0 : idx_ff + 2'd1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      last_ff <= last_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.unit_value  = item_ff.value;
   assign rsp.error_kind  = ERR_W'(item_ff.err);
   assign rsp.last_of_run = last_ff;

endmodule

[hw/rtl/utf8_stream_transcoder.sv]
`timescale 1ns / 1ps
// Streaming UTF-8 decoder. Bytes enter on req_chan and each beat is classified at once, so the
// input takes one byte per cycle while the job queue has room. Every beat that produces output
// becomes one queued job, and the result side spends one cycle per result beat while rsp_chan is
// ready: one beat for a code point or error, two for a surrogate pair, and up to four when the
// original bytes are passed through. A run of bytes that produce one result each flows at one
// byte per cycle while rsp_chan is ready; multi-result bytes hold the input back only once the
// queue of QUEUE_DEPTH jobs fills. A result goes through the job queue, then the output register.
// The output form in csr_wdata should be written only while no results are pending.
`include "utf8_stream_transcoder_assert.svh"
module utf8_stream_transcoder import utf8st_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   utf8st_req_if.sink        req_chan,
   utf8st_rsp_if.source      rsp_chan,
   input  logic              csr_we,
   input  logic [FORM_W-1:0] csr_wdata
);

   logic [FORM_W-1:0] form_ff, form_in;
   logic              q_full;
   logic              q_push;
   job_type           q_push_job;
   logic              q_pop;
   logic              q_valid;
   job_type           q_job;

   assign form_in = csr_we ? csr_wdata : form_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         form_ff <= FORM_UTF32;
      end else begin
         form_ff <= form_in;
      end
   end

   utf8st_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .form     (form_ff),
      .q_full   (q_full),
      .push     (q_push),
      .push_job (q_push_job)
   );

   utf8st_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_job   (q_job)
   );

   utf8st_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job       (q_job),
      .pop       (q_pop),
      .rsp       (rsp_chan)
   );

   `UTF8ST_ASSERT_SAME(a_err_value_zero, rsp_chan.valid && rsp_chan.error_kind != ERR_NONE, rsp_chan.unit_value == '0, "Error beat carries a nonzero value.")
   `UTF8ST_ASSERT_SAME(a_err_known, rsp_chan.valid, rsp_chan.error_kind <= ERR_RANGE, "Unknown error kind.")
   `UTF8ST_ASSERT_SAME(a_utf16_width, rsp_chan.valid && rsp_chan.error_kind == ERR_NONE && form_ff == FORM_UTF16, rsp_chan.unit_value[UNIT_W-1:16] == '0, "UTF-16 unit wider than 16 bits.")
   `UTF8ST_ASSERT_NEXT(a_push_lands, q_push, q_valid, "Queued job not visible to the back end.")

endmodule

[tb/tb_utf8_stream_transcoder.sv]
`timescale 1ns / 1ps
module tb_utf8_stream_transcoder;
   import utf8st_pkg::*;

   localparam logic [FORM_W-1:0] FORM_UNUSED = 2'd3;
   localparam int IDLE_PCT     = 29;
   localparam int SETTLE_TICKS = 8;
   localparam int HOLD_TICKS   = 80;
   localparam int HOLD_AFTER   = 110;
   localparam int PHASE_BEATS  = 35;
   localparam int STUCK_LIMIT  = 2000;

   // Bit 8 of each entry is the end-of-stream flag, bits 7:0 the byte.
   localparam logic [8:0] UTF32_BEATS [13] = '{
      9'h000, 9'h07F, 9'h0C2, 9'h0A9, 9'h080, 9'h0FF, 9'h0E2,
      9'h041, 9'h0C3, 9'h0C3, 9'h0A9, 9'h0E2, 9'h182};
   localparam logic [8:0] UTF16_BEATS [9] = '{
      9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h0F4, 9'h090, 9'h080, 9'h080, 9'h1C3};
   localparam logic [8:0] UTF8_BEATS [3] = '{9'h0E2, 9'h082, 9'h0AC};

   class utf8_decode_tracker;
      typedef struct packed {
         logic [UNIT_W-1:0] value;
         err_type           err;
         logic              last;
      } unit_rec;

      unit_rec           expected_units[$];
      unit_rec           step_units[$];
      logic [FORM_W-1:0] form;
      logic [LEN_W-1:0]  seq_len;
      logic [LEN_W-1:0]  seq_count;
      logic [UNIT_W-1:0] acc_cp;
      logic [BYTE_W-1:0] seq_bytes [MAX_BYTES];
      int                bytes_seen;
      int                error_count;

      function new();
         form = FORM_UTF32;
         seq_len = '0;
         seq_count = '0;
         acc_cp = '0;
         bytes_seen = 0;
         error_count = 0;
         foreach (seq_bytes[i]) seq_bytes[i] = '0;
      endfunction

      function int pending();
         return expected_units.size();
      endfunction

      function void add_unit(logic [UNIT_W-1:0] value, err_type err);
         unit_rec u;
         u.value = value;
         u.err = err;
         u.last = 1'b0;
         if (step_units.size() < MAX_BYTES) step_units.push_back(u);
      endfunction

      function void drop_sequence();
         seq_len = '0;
         seq_count = '0;
         acc_cp = '0;
      endfunction

      function void finish_sequence(logic [UNIT_W-1:0] cp, logic [LEN_W-1:0] len);
         logic [UNIT_W-1:0] offset;
         case (form)
            FORM_UTF8: begin
               for (int i = 0; i < len && i < MAX_BYTES; i++) add_unit(seq_bytes[i], ERR_NONE);
            end
            FORM_UTF16: begin
               if (cp >= CP_LIMIT) begin
                  add_unit('0, ERR_RANGE);
               end else if (cp < SUPP_BASE) begin
                  add_unit(cp, ERR_NONE);
               end else begin
                  offset = cp - SUPP_BASE;
                  add_unit(HI_SURR | ((offset >> 10) & 21'h3FF), ERR_NONE);
                  add_unit(LO_SURR | (offset & 21'h3FF), ERR_NONE);
               end
            end
            default: add_unit(cp, ERR_NONE);
         endcase
      endfunction

      function void open_lead(logic [BYTE_W-1:0] b, logic eos);
         logic [LEN_W-1:0]  len;
         logic [UNIT_W-1:0] bits;
         casez (b)
            8'b0???????: begin len = 3'd1; bits = {14'd0, b[6:0]}; end
            8'b110?????: begin len = 3'd2; bits = {16'd0, b[4:0]}; end
            8'b1110????: begin len = 3'd3; bits = {17'd0, b[3:0]}; end
            8'b11110???: begin len = 3'd4; bits = {18'd0, b[2:0]}; end
            default: begin
               add_unit('0, ERR_BAD_LEAD);
               return;
            end
         endcase
         seq_bytes[0] = b;
         if (len == 3'd1) begin
            finish_sequence(bits, len);
            drop_sequence();
            return;
         end
         seq_len = len;
         seq_count = 3'd1;
         acc_cp = bits;
         if (eos) begin
            add_unit('0, ERR_TRUNC);
            drop_sequence();
         end
      endfunction

      function void note_byte(logic [BYTE_W-1:0] b, logic eos);
         step_units.delete();
         bytes_seen++;
         if (seq_len == '0) begin
            open_lead(b, eos);
         end else if (b[7:6] == 2'b10) begin
            seq_bytes[seq_count[1:0]] = b;
            acc_cp = {acc_cp[UNIT_W-7:0], b[5:0]};
            seq_count = seq_count + 3'd1;
            if (seq_count >= seq_len) begin
               finish_sequence(acc_cp, seq_len);
               drop_sequence();
            end else if (eos) begin
               add_unit('0, ERR_TRUNC);
               drop_sequence();
            end
         end else begin
            add_unit('0, ERR_BAD_CONT);
            drop_sequence();
            open_lead(b, eos);
         end
         if (step_units.size() > 0) step_units[step_units.size()-1].last = 1'b1;
         foreach (step_units[i]) expected_units.push_back(step_units[i]);
      endfunction

      function void check_unit(logic [UNIT_W-1:0] value, logic [ERR_W-1:0] err, logic last);
         unit_rec want;
         if (expected_units.size() == 0) begin
            $error("unexpected result beat: unit_value %0h error_kind %0d", value, err);
            error_count++;
            return;
         end
         want = expected_units.pop_front();
         if (value !== want.value) begin
            $error("unit_value: expected %0h, actual %0h", want.value, value);
            error_count++;
         end
         if (err !== want.err) begin
            $error("error_kind: expected %0d, actual %0d", want.err, err);
            error_count++;
         end
         if (last !== want.last) begin
            $error("last_of_run: expected %0d, actual %0d", want.last, last);
            error_count++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic [FORM_W-1:0] csr_wdata;
   logic              steady_run;
   int                stuck_ticks;

   utf8_decode_tracker tracker = new();

   utf8st_req_if req_chan ();
   utf8st_rsp_if rsp_chan ();

   utf8_stream_transcoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
      while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.end_of_stream <= eos;
      do @(posedge clock); while (!req_chan.ready);
      tracker.note_byte(b, eos);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_form(input logic [FORM_W-1:0] f);
      csr_we <= 1'b1;
      csr_wdata <= f;
      tracker.form = f;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly well-formed sequences with random payload bits; the rest are raw noise bytes
   // or sequences cut short so that the next lead lands as a bad continuation.
   task automatic send_sequence();
      int                pick;
      int                len;
      int                cut;
      logic [BYTE_W-1:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         send_byte(8'($urandom), $urandom_range(0, 99) < 5);
         return;
      end
      len = $urandom_range(1, 4);
      cut = (pick < 24) ? $urandom_range(1, len) : len;
      for (int k = 0; k < cut; k++) begin
         if (k == 0) begin
            case (len)
               1: b = {1'b0, 7'($urandom)};
               2: b = {3'b110, 5'($urandom)};
               3: b = {4'b1110, 4'($urandom)};
               default: b = {5'b11110, 3'($urandom)};
            endcase
         end else begin
            b = {2'b10, 6'($urandom)};
         end
         send_byte(b, (k == cut - 1) ? ($urandom_range(0, 99) < 8) : ($urandom_range(0, 99) < 2));
      end
   endtask

   initial begin
      bit hold_done;
      int hold_left;
      hold_done = 1'b0;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && tracker.bytes_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_TICKS;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         tracker.check_unit(rsp_chan.unit_value, rsp_chan.error_kind, rsp_chan.last_of_run);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stuck_ticks <= 0;
      end else if (stuck_ticks >= STUCK_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stuck_ticks <= stuck_ticks + 1;
      end
   end

   initial begin
      logic [FORM_W-1:0] phase_form;
      int                phase_end;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      steady_run = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.in_byte = '0;
      req_chan.end_of_stream = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_form(FORM_UTF32);
      foreach (UTF32_BEATS[i]) send_byte(UTF32_BEATS[i][7:0], UTF32_BEATS[i][8]);
      wait_drained();
      write_form(FORM_UTF16);
      foreach (UTF16_BEATS[i]) send_byte(UTF16_BEATS[i][7:0], UTF16_BEATS[i][8]);
      wait_drained();
      write_form(FORM_UTF8);
      foreach (UTF8_BEATS[i]) send_byte(UTF8_BEATS[i][7:0], UTF8_BEATS[i][8]);

      for (int p = 0; p < 5; p++) begin
         wait_drained();
         case (p)
            0: phase_form = FORM_UTF16;
            1: phase_form = FORM_UTF8;
            2: phase_form = FORM_UNUSED;
            3: phase_form = FORM_UTF32;
            default: phase_form = FORM_W'($urandom_range(0, 3));
         endcase
         write_form(phase_form);
         steady_run <= (p == 2);
         phase_end = tracker.bytes_seen + PHASE_BEATS;
         while (tracker.bytes_seen < phase_end) begin
            send_sequence();
            if (p == 1 && tracker.bytes_seen == phase_end - PHASE_BEATS / 2) wait_drained();
         end
      end

      wait_drained();
      if (tracker.error_count == 0 && tracker.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
